@@ rtl/assert_macros.svh @@
// Assertion macros shared by the SM3 hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`endif

@@ rtl/sm3_pkg.sv @@
// Shared types, constants and round functions of the SM3 hasher.
package sm3_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = 2;

   typedef logic [31:0] word_type;

   // One request as it passes from the front end to the engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } request_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXPAND,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_EMIT
   } engine_state_type;

   localparam word_type Iv [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   localparam word_type TLow  = 32'h79CC4519;
   localparam word_type THigh = 32'h7A879D8A;
   localparam logic [7:0] PadByte = 8'h80;

   function automatic word_type rol32(input word_type x, input logic [4:0] n);
      logic [63:0] dbl;
      begin
         dbl = {x, x} << n;
         return dbl[63:32];
      end
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
   endfunction

endpackage

@@ rtl/sm3_queue.sv @@
// Small request queue between the front end and the compression engine.
module sm3_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  sm3_pkg::request_type wr_data,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output sm3_pkg::request_type rd_data
);

   sm3_pkg::request_type                 mem_ff [sm3_pkg::QueueDepth];
   logic [sm3_pkg::QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sm3_pkg::QueuePtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sm3_pkg::QueuePtrWidth:0]      count_ff, count_in;
   logic                                 push, pop;

   assign wr_ready = (count_ff != 3'(sm3_pkg::QueueDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/sm3_engine.sv @@
// SM3 back end: block buffer, message expansion, 64 rounds, padding and digest output.
module sm3_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sm3_pkg::request_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word,
   output logic                 busy
);

   sm3_pkg::engine_state_type state_ff, state_in;

   // The block is held as sixteen big-endian words, written one byte lane at a time.
   logic [31:0] buf_ff [16];
   logic [6:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic        ending_ff, ending_in;
   logic        final_ff, final_in;
   logic        pad_more_ff, pad_more_in;
   logic [6:0]  step_ff, step_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   sm3_pkg::word_type v_ff [8];
   sm3_pkg::word_type r_ff [8];
   sm3_pkg::word_type w_ff [16];

   logic                buf_we;
   logic [5:0]          buf_addr;
   logic [7:0]          buf_wdata;
   logic                load_word;
   logic                shift_w;
   logic                do_round;
   logic                do_update;
   logic                reset_chain;
   logic                start_round;

   sm3_pkg::word_type   w_new, load_val, a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
   logic [63:0]         bits;
   logic [5:0]          j;

   assign j = step_ff[5:0];
   assign tj = (step_ff < 7'd16) ? sm3_pkg::TLow : sm3_pkg::THigh;
   assign w_new = sm3_pkg::perm1(w_ff[0] ^ w_ff[7] ^ sm3_pkg::rol32(w_ff[13], 5'd15))
                  ^ sm3_pkg::rol32(w_ff[3], 5'd7) ^ w_ff[10];
   assign load_val = buf_ff[step_ff[3:0]];
   assign a12 = sm3_pkg::rol32(r_ff[0], 5'd12);
   assign ss1 = sm3_pkg::rol32(a12 + r_ff[4] + sm3_pkg::rol32(tj, j[4:0]), 5'd7);
   assign ss2 = ss1 ^ a12;
   assign bits = {count_ff, 3'b000};

   always_comb begin
      if (step_ff < 7'd16) begin
         ffv = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         ggv = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ffv = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         ggv = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ffv + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = ggv + r_ff[7] + ss1 + w_ff[0];
   end

   // The round window keeps 16 words: w_ff[0] is W[j], and each round slides it.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      ending_in   = ending_ff;
      final_in    = final_ff;
      pad_more_in = pad_more_ff;
      step_in     = step_ff;
      out_idx_in  = out_idx_ff;
      buf_we      = 1'b0;
      buf_addr    = fill_ff[5:0];
      buf_wdata   = req_data.data_byte;
      load_word   = 1'b0;
      shift_w     = 1'b0;
      do_round    = 1'b0;
      do_update   = 1'b0;
      reset_chain = 1'b0;
      start_round = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         sm3_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ending_in = req_data.end_of_message;
               if (req_data.byte_valid) begin
                  buf_we   = 1'b1;
                  count_in = count_ff + 61'd1;
                  if (fill_ff == 7'd63) begin
                     fill_in  = '0;
                     final_in = 1'b0;
                     step_in  = '0;
                     state_in = sm3_pkg::ST_LOAD;
                  end else begin
                     fill_in = fill_ff + 7'd1;
                     if (req_data.end_of_message) begin
                        state_in = sm3_pkg::ST_PAD;
                     end
                  end
               end else if (req_data.end_of_message) begin
                  state_in = sm3_pkg::ST_PAD;
               end
            end
         end
         sm3_pkg::ST_PAD: begin
            // Writes 0x80, zeros and the length, one byte per cycle.
            buf_we = 1'b1;
            if (ending_ff) begin
               buf_wdata   = sm3_pkg::PadByte;
               ending_in   = 1'b0;
               final_in    = (fill_ff < 7'd56);
               pad_more_in = (fill_ff >= 7'd56);
            end else if (final_ff && fill_ff >= 7'd56) begin
               buf_wdata = bits[8'(7'd63 - fill_ff) * 8 +: 8];
            end else begin
               buf_wdata = 8'h00;
            end
            if (fill_ff == 7'd63) begin
               fill_in  = '0;
               step_in  = '0;
               state_in = sm3_pkg::ST_LOAD;
            end else begin
               fill_in = fill_ff + 7'd1;
            end
         end
         sm3_pkg::ST_LOAD: begin
            load_word = 1'b1;
            step_in   = step_ff + 7'd1;
            if (step_ff == 7'd15) begin
               step_in     = '0;
               start_round = 1'b1;
               state_in    = sm3_pkg::ST_ROUND;
            end
         end
         sm3_pkg::ST_ROUND: begin
            do_round = 1'b1;
            shift_w  = 1'b1;
            step_in  = step_ff + 7'd1;
            if (step_ff == 7'd63) begin
               state_in = sm3_pkg::ST_UPDATE;
            end
         end
         sm3_pkg::ST_UPDATE: begin
            do_update = 1'b1;
            if (final_ff) begin
               out_idx_in = '0;
               state_in   = sm3_pkg::ST_EMIT;
            end else if (ending_ff) begin
               state_in = sm3_pkg::ST_PAD;
            end else if (pad_more_ff) begin
               // Second pad block after an overflowing 0x80.
               pad_more_in = 1'b0;
               final_in    = 1'b1;
               state_in    = sm3_pkg::ST_PAD;
            end else begin
               state_in = sm3_pkg::ST_IDLE;
            end
         end
         sm3_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  reset_chain = 1'b1;
                  fill_in     = '0;
                  count_in    = '0;
                  final_in    = 1'b0;
                  ending_in   = 1'b0;
                  pad_more_in = 1'b0;
                  state_in    = sm3_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sm3_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = (state_ff == sm3_pkg::ST_EMIT);
   assign rsp_digest_word = v_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);
   assign busy            = (state_ff != sm3_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sm3_pkg::ST_IDLE;
         fill_ff     <= '0;
         count_ff    <= '0;
         ending_ff   <= 1'b0;
         final_ff    <= 1'b0;
         pad_more_ff <= 1'b0;
         step_ff     <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         ending_ff   <= ending_in;
         final_ff    <= final_in;
         pad_more_ff <= pad_more_in;
         step_ff     <= step_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[buf_addr[5:2]][{~buf_addr[1:0], 3'b000} +: 8] <= buf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || reset_chain) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= sm3_pkg::Iv[i];
         end
      end else if (do_update) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= v_ff[i] ^ r_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_round) begin
         for (int i = 0; i < 8; i++) begin
            r_ff[i] <= v_ff[i];
         end
      end else if (do_round) begin
         r_ff[0] <= tt1;
         r_ff[1] <= r_ff[0];
         r_ff[2] <= sm3_pkg::rol32(r_ff[1], 5'd9);
         r_ff[3] <= r_ff[2];
         r_ff[4] <= sm3_pkg::perm0(tt2);
         r_ff[5] <= r_ff[4];
         r_ff[6] <= sm3_pkg::rol32(r_ff[5], 5'd19);
         r_ff[7] <= r_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (load_word) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= load_val;
      end else if (shift_w) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end
   end

endmodule

@@ rtl/sm3_stream_hasher.sv @@
// SM3 hasher: byte stream in through a request queue, 256-bit digest out as eight words.
// A byte that fills a block starts the load, round and update states, in that order.
// End of message pads one byte per cycle, then loads, rounds and updates each pad block, then 8 words.
// Throughput: one byte per cycle between blocks; the single round unit sets the block rate.
// Synchronous active-high reset restores the SM3 IV and clears the counts and queue.
`include "assert_macros.svh"
module sm3_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sm3_pkg::request_type in_req, q_req;
   logic                 q_valid, q_ready, busy;

   assign in_req.data_byte      = req_data_byte;
   assign in_req.byte_valid     = req_byte_valid;
   assign in_req.end_of_message = req_end_of_message;

   sm3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  (in_req),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_req)
   );

   sm3_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (q_valid),
      .req_ready       (q_ready),
      .req_data        (q_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .busy            (busy)
   );

   `ASSERT_IMPLY(a_rsp_only_busy, clock, reset, rsp_valid, busy)
   `ASSERT_IMPLY(a_no_take_busy, clock, reset, q_ready, !busy)
   `ASSERT_IMPLY(a_idx_advance, clock, reset, rsp_valid && rsp_ready && !rsp_last_word,
                 ##1 (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the streaming SM3 hasher.
`timescale 1ns / 100ps
module tb;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } byte_request_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   byte_request_type pending_requests[$];
   digest_rsp_type   expected_digests[$];
   int  error_count = 0;
   int  hold_off_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;

   // Hash state of the predictor.
   sm3_pkg::word_type hash_words[8];
   logic [7:0]  msg_block[64];
   int          msg_fill;
   logic [60:0] msg_bytes;

   sm3_stream_hasher u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic sm3_pkg::word_type rotl(sm3_pkg::word_type x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic sm3_pkg::word_type mix0(sm3_pkg::word_type x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic sm3_pkg::word_type mix1(sm3_pkg::word_type x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_words[i] = sm3_pkg::Iv[i];
      msg_fill = 0;
      msg_bytes = '0;
   endtask

   task automatic compress_msg_block();
      sm3_pkg::word_type w[68];
      sm3_pkg::word_type a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, t1, t2, tj;
      for (int j = 0; j < 16; j++)
         w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
      for (int j = 16; j < 68; j++)
         w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
      a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
      e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
      for (int j = 0; j < 64; j++) begin
         tj = (j < 16) ? sm3_pkg::TLow : sm3_pkg::THigh;
         a12 = rotl(a, 12);
         ss1 = rotl(a12 + e + rotl(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         t1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         t2 = gg + h + ss1 + w[j];
         d = c; c = rotl(b, 9); b = a; a = t1;
         h = g; g = rotl(f, 19); f = e; e = mix0(t2);
      end
      hash_words[0] ^= a; hash_words[1] ^= b; hash_words[2] ^= c; hash_words[3] ^= d;
      hash_words[4] ^= e; hash_words[5] ^= f; hash_words[6] ^= g; hash_words[7] ^= h;
   endtask

   task automatic predict_digest(byte_request_type r);
      logic [63:0] bit_len;
      digest_rsp_type x;
      if (r.byte_valid) begin
         msg_block[msg_fill] = r.data_byte;
         msg_fill++;
         msg_bytes = msg_bytes + 61'd1;
         if (msg_fill == 64) begin
            compress_msg_block();
            msg_fill = 0;
         end
      end
      if (r.end_of_message) begin
         msg_block[msg_fill] = sm3_pkg::PadByte;
         msg_fill++;
         if (msg_fill > 56) begin
            while (msg_fill < 64) begin
               msg_block[msg_fill] = 8'h00;
               msg_fill++;
            end
            compress_msg_block();
            msg_fill = 0;
         end
         while (msg_fill < 56) begin
            msg_block[msg_fill] = 8'h00;
            msg_fill++;
         end
         bit_len = {msg_bytes, 3'b000};
         for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
         compress_msg_block();
         for (int i = 0; i < 8; i++) begin
            x.digest_word = hash_words[i];
            x.word_index = i[2:0];
            x.last_word = (i == 7);
            expected_digests.push_back(x);
         end
         restart_hash();
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic push_message(int len, bit end_with_byte);
      byte_request_type r;
      for (int i = 0; i < len; i++) begin
         r.data_byte = 8'($urandom_range(0, 255));
         r.byte_valid = 1'b1;
         r.end_of_message = end_with_byte && (i == len - 1);
         pending_requests.push_back(r);
      end
      if (!end_with_byte || len == 0) begin
         r.data_byte = 8'($urandom_range(0, 255));
         r.byte_valid = 1'b0;
         r.end_of_message = 1'b1;
         pending_requests.push_back(r);
      end
   endtask

   // Driver: the request payload changes only after acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_digest({req_data_byte, req_byte_valid, req_end_of_message});
            send_gap <= pick_gap();
            req_valid <= 1'b0;
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            else if (pending_requests.size() > 0) begin
               {req_data_byte, req_byte_valid, req_end_of_message} <=
                  pending_requests.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      digest_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
               error_count++;
            end else begin
               exp_rsp = expected_digests.pop_front();
               if (exp_rsp.digest_word !== rsp_digest_word)
                  $display("%0t: digest_word expected %h actual %h", $time,
                     exp_rsp.digest_word, rsp_digest_word);
               if (exp_rsp.word_index !== rsp_word_index)
                  $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_rsp.word_index, rsp_word_index);
               if (exp_rsp.last_word !== rsp_last_word)
                  $display("%0t: last_word expected %0b actual %0b", $time,
                     exp_rsp.last_word, rsp_last_word);
               if (exp_rsp !== {rsp_digest_word, rsp_word_index, rsp_last_word})
                  error_count++;
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready) recv_gap <= pick_gap();
         end
      end
   end

   initial begin
      restart_hash();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Directed messages: empty, one byte with its end together, three bytes then a separate end.
      push_message(0, 1'b0);
      push_message(1, 1'b1);
      push_message(3, 1'b0);
      wait (pending_requests.size() == 0 && expected_digests.size() == 0);
      // Long receiver stall while a message streams in so the queue backs up.
      hold_off_cycles = 400;
      push_message(2, 1'b1);
      push_message(1, 1'b1);
      push_message(1, 1'b1);
      push_message(1, 1'b1);
      push_message(0, 1'b0);
      push_message(1, 1'b1);
      // Extreme bytes, a noise item, a full block ending on its last byte,
      // and the two-block pad case.
      pending_requests.push_back({8'hFF, 1'b1, 1'b0});
      pending_requests.push_back({8'hA5, 1'b0, 1'b0});
      pending_requests.push_back({8'h00, 1'b1, 1'b1});
      push_message(64, 1'b1);
      push_message(56, 1'b1);
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 2))
            0: push_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
            1: pending_requests.push_back({8'($urandom_range(0, 255)), 1'b0, 1'b0});
            default: push_message($urandom_range(9, 20), 1'($urandom_range(0, 1)));
         endcase
      end
      push_message(0, 1'b0);
      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_digests.size() == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_digests.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
